// ===== rtl/core/psp_pkg.sv =====
// Shared types, constants and character helpers for the pipe spec parser.
`default_nettype none

package psp_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int OFS_W  = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    localparam logic [1:0] REG_DEFAULT_SIZE = 2'd0;
    localparam logic [1:0] REG_SIZE_LIMIT   = 2'd1;
    localparam logic [1:0] REG_SEPARATOR    = 2'd2;
    localparam logic [1:0] REG_CONSOLE_ONLY = 2'd3;

    localparam logic [31:0] DEFAULT_SIZE_RST = 32'd4096;
    localparam logic [31:0] SIZE_LIMIT_RST   = 32'd65535;
    localparam logic [7:0]  SEPARATOR_RST    = 8'h2F;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h58;

    localparam logic [7:0] CON_TEXT [4] = '{8'h43, 8'h4F, 8'h4E, 8'h3A};
    localparam logic [2:0] CON_DONE = 3'd4;
    localparam logic [2:0] CON_FAIL = 3'd7;

    localparam logic [1:0] TAP_NONE    = 2'd0;
    localparam logic [1:0] TAP_DEFAULT = 2'd1;
    localparam logic [1:0] TAP_GIVEN   = 2'd2;

    typedef enum logic [2:0] {
        PH_NAME       = 3'd0,
        PH_SIZE_START = 3'd1,
        PH_ZERO       = 3'd2,
        PH_DIGITS     = 3'd3,
        PH_TAP_START  = 3'd4,
        PH_TAP        = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef struct packed {
        logic [31:0] default_size;
        logic [31:0] size_limit;
        logic [7:0]  separator;
        logic        console_only;
    } cfg_t;

    typedef struct packed {
        logic             parse_ok;
        logic [31:0]      pipe_size;
        logic [OFS_W-1:0] name_start;
        logic [OFS_W-1:0] name_length;
        logic [1:0]       tap_kind;
        logic [OFS_W-1:0] tap_start;
    } result_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c inside {[8'h61:8'h7A]})
        begin
            u = c - 8'd32;
        end
        return u;
    endfunction

    // 16 marks a character that is no hex digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] v;
        u = upcase(c);
        v = 5'd16;
        if (u inside {[8'h30:8'h39]})
        begin
            v = 5'(u - CHAR_ZERO);
        end
        else if (u inside {[8'h41:8'h46]})
        begin
            v = 5'(u - 8'h41) + 5'd10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psp_apb_regs.sv =====
// APB configuration register file of the pipe spec parser.
`default_nettype none

module psp_apb_regs
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [psp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [psp_pkg::DATA_W-1:0] pwdata,
    output logic      [psp_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output psp_pkg::cfg_t                  cfg
);
    import psp_pkg::*;

    logic [31:0] default_size_reg;
    logic [31:0] size_limit_reg;
    logic [7:0]  separator_reg;
    logic        console_only_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_size_reg <= DEFAULT_SIZE_RST;
            size_limit_reg   <= SIZE_LIMIT_RST;
            separator_reg    <= SEPARATOR_RST;
            console_only_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEFAULT_SIZE: default_size_reg <= pwdata;
                REG_SIZE_LIMIT:   size_limit_reg   <= pwdata;
                REG_SEPARATOR:    separator_reg    <= pwdata[7:0];
                REG_CONSOLE_ONLY: console_only_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEFAULT_SIZE: prdata = default_size_reg;
            REG_SIZE_LIMIT:   prdata = size_limit_reg;
            REG_SEPARATOR:    prdata = {24'd0, separator_reg};
            REG_CONSOLE_ONLY: prdata = {31'd0, console_only_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.default_size = default_size_reg;
    assign cfg.size_limit   = size_limit_reg;
    assign cfg.separator    = separator_reg;
    assign cfg.console_only = console_only_reg;

endmodule

`default_nettype wire

// ===== rtl/core/psp_parser.sv =====
// Per-character parse state and result logic of the pipe spec parser.
`default_nettype none

module psp_parser
#(
    parameter int NAME_CAPACITY = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire psp_pkg::cfg_t cfg,
    input  wire logic       step_en,
    input  wire logic [7:0] step_char,
    input  wire logic       step_present,
    input  wire logic       step_final,
    output psp_pkg::result_t result
);
    import psp_pkg::*;

    localparam int CW = $clog2(NAME_CAPACITY);
    localparam logic [CW-1:0] CAP_LAST = CW'(NAME_CAPACITY - 1);

    phase_t        phase_reg,  phase_upd,  phase_next;
    radix_t        radix_reg,  radix_upd,  radix_next;
    logic          colon_reg,  colon_upd,  colon_next;
    logic          ended_reg,  ended_upd,  ended_next;
    logic          err_reg,    err_upd,    err_next;
    logic [CW-1:0] count_reg,  count_upd,  count_next;
    logic [CW-1:0] origin_reg, origin_upd, origin_next;
    logic [CW-1:0] span_reg,   span_upd,   span_next;
    logic [CW-1:0] tap_reg,    tap_upd,    tap_next;
    logic [31:0]   acc_reg,    acc_upd,    acc_next;
    logic [2:0]    con_reg,    con_upd,    con_next;

    logic [7:0]    ch_up;
    logic [4:0]    dval;
    radix_t        dig_radix;
    logic [4:0]    radix_num;
    logic [35:0]   acc_scaled;
    logic [35:0]   acc_sum;
    logic          dig_ok;
    logic          dig_over;
    logic [2:0]    con_step;
    logic          take;
    logic          clear;

    assign ch_up = upcase(step_char);
    assign dval  = digit_value(step_char);

    // a leading zero switches the first digit step to octal
    assign dig_radix = (phase_reg == PH_ZERO) ? RADIX_OCT : radix_reg;

    always_comb
    begin
        case (dig_radix)
            RADIX_HEX:
            begin
                radix_num  = 5'd16;
                acc_scaled = {acc_reg, 4'b0};
            end
            RADIX_OCT:
            begin
                radix_num  = 5'd8;
                acc_scaled = {1'b0, acc_reg, 3'b0};
            end
            default:
            begin
                radix_num  = 5'd10;
                acc_scaled = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0};
            end
        endcase
    end

    assign acc_sum  = acc_scaled + 36'(dval);
    assign dig_ok   = dval < radix_num;
    assign dig_over = acc_sum > {4'd0, cfg.size_limit};

    always_comb
    begin
        con_step = con_reg;
        if (con_reg < CON_DONE)
        begin
            con_step = (ch_up == CON_TEXT[con_reg[1:0]]) ? con_reg + 3'd1 : CON_FAIL;
        end
    end

    assign take = step_en && step_present && !ended_reg && (step_char != CHAR_NUL)
                  && (count_reg < CAP_LAST);

    // state after the character of this transaction
    always_comb
    begin
        phase_upd  = phase_reg;
        radix_upd  = radix_reg;
        colon_upd  = colon_reg;
        ended_upd  = ended_reg;
        err_upd    = err_reg;
        count_upd  = count_reg;
        origin_upd = origin_reg;
        span_upd   = span_reg;
        tap_upd    = tap_reg;
        acc_upd    = acc_reg;
        con_upd    = con_reg;

        if (step_en && step_present && !ended_reg && (step_char == CHAR_NUL))
        begin
            ended_upd = 1'b1;
        end

        if (take)
        begin
            count_upd = count_reg + CW'(1);
            if (!colon_reg && (step_char == CHAR_COLON))
            begin
                colon_upd  = 1'b1;
                phase_upd  = PH_NAME;
                radix_upd  = RADIX_DEC;
                err_upd    = 1'b0;
                origin_upd = count_reg + CW'(1);
                span_upd   = '0;
                tap_upd    = '0;
                acc_upd    = '0;
                con_upd    = '0;
            end
            else if (!err_reg)
            begin
                case (phase_reg)
                    PH_NAME:
                    begin
                        if (step_char == cfg.separator)
                        begin
                            phase_upd = PH_SIZE_START;
                        end
                        else
                        begin
                            span_upd = span_reg + CW'(1);
                        end
                    end
                    PH_SIZE_START:
                    begin
                        if (step_char inside {[8'h30:8'h39]})
                        begin
                            if (step_char == CHAR_ZERO)
                            begin
                                phase_upd = PH_ZERO;
                            end
                            else
                            begin
                                radix_upd = RADIX_DEC;
                                acc_upd   = 32'(dval);
                                err_upd   = 32'(dval) > cfg.size_limit;
                                phase_upd = PH_DIGITS;
                            end
                        end
                        else
                        begin
                            tap_upd   = count_reg;
                            phase_upd = PH_TAP;
                            con_upd   = con_step;
                        end
                    end
                    PH_ZERO, PH_DIGITS:
                    begin
                        phase_upd = PH_DIGITS;
                        if ((phase_reg == PH_ZERO) && (ch_up == CHAR_X))
                        begin
                            radix_upd = RADIX_HEX;
                        end
                        else
                        begin
                            radix_upd = dig_radix;
                            if (dig_ok)
                            begin
                                if (dig_over)
                                begin
                                    err_upd = 1'b1;
                                end
                                else
                                begin
                                    acc_upd = acc_sum[31:0];
                                end
                            end
                            else if (step_char == cfg.separator)
                            begin
                                if (acc_reg == '0)
                                begin
                                    err_upd = 1'b1;
                                end
                                else
                                begin
                                    phase_upd = PH_TAP_START;
                                end
                            end
                            else
                            begin
                                err_upd = 1'b1;
                            end
                        end
                    end
                    PH_TAP_START:
                    begin
                        tap_upd   = count_reg;
                        phase_upd = PH_TAP;
                        con_upd   = con_step;
                    end
                    default:
                    begin
                        con_upd = con_step;
                    end
                endcase
            end
        end
    end

    // result of the string, taken from the updated state
    always_comb
    begin
        result.parse_ok    = !err_upd;
        result.pipe_size   = cfg.default_size;
        result.tap_kind    = TAP_NONE;
        result.tap_start   = '0;
        result.name_start  = OFS_W'(origin_upd);
        result.name_length = OFS_W'(span_upd);
        case (phase_upd)
            PH_SIZE_START:
            begin
                result.tap_kind = TAP_DEFAULT;
            end
            PH_ZERO, PH_DIGITS:
            begin
                if (acc_upd == '0)
                begin
                    result.parse_ok = 1'b0;
                end
                result.pipe_size = acc_upd;
            end
            PH_TAP_START:
            begin
                result.pipe_size = acc_upd;
                result.tap_kind  = TAP_DEFAULT;
            end
            PH_TAP:
            begin
                if (acc_upd != '0)
                begin
                    result.pipe_size = acc_upd;
                end
                result.tap_kind  = TAP_GIVEN;
                result.tap_start = OFS_W'(tap_upd);
                if (cfg.console_only && (con_upd != CON_DONE))
                begin
                    result.parse_ok = 1'b0;
                end
            end
            default: ;
        endcase
        if (!result.parse_ok)
        begin
            result.pipe_size = '0;
            result.tap_kind  = TAP_NONE;
            result.tap_start = '0;
        end
    end

    assign clear = step_en && step_final;

    assign phase_next  = clear ? PH_NAME   : phase_upd;
    assign radix_next  = clear ? RADIX_DEC : radix_upd;
    assign colon_next  = clear ? 1'b0      : colon_upd;
    assign ended_next  = clear ? 1'b0      : ended_upd;
    assign err_next    = clear ? 1'b0      : err_upd;
    assign count_next  = clear ? '0        : count_upd;
    assign origin_next = clear ? '0        : origin_upd;
    assign span_next   = clear ? '0        : span_upd;
    assign tap_next    = clear ? '0        : tap_upd;
    assign acc_next    = clear ? '0        : acc_upd;
    assign con_next    = clear ? '0        : con_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NAME;
            radix_reg  <= RADIX_DEC;
            colon_reg  <= 1'b0;
            ended_reg  <= 1'b0;
            err_reg    <= 1'b0;
            count_reg  <= '0;
            origin_reg <= '0;
            span_reg   <= '0;
            tap_reg    <= '0;
            acc_reg    <= '0;
            con_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            radix_reg  <= radix_next;
            colon_reg  <= colon_next;
            ended_reg  <= ended_next;
            err_reg    <= err_next;
            count_reg  <= count_next;
            origin_reg <= origin_next;
            span_reg   <= span_next;
            tap_reg    <= tap_next;
            acc_reg    <= acc_next;
            con_reg    <= con_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pipe_spec_parser.sv =====
// Top level of the pipe spec parser: input register, parser and result register.
//
// Usage:
//   The slave stream carries one character of a name string per transaction;
//   s_tlast marks the last transaction of a string. Exactly one result
//   transaction appears on the master stream per string, with m_tlast high.
//   Non-final characters produce no output.
//   Registers (APB, byte address 4*i): 0 default size, 1 size limit,
//   2 separator character, 3 console tap only. Write them only while idle.
// Pipeline and throughput:
//   One transaction per cycle unless a final character waits on a stalled
//   result. A final character passes two register stages (input register,
//   result register) on its way to m_tvalid. The per-character state update
//   is combinational, with the size accumulator shift-add and limit compare.
// Reset:
//   rst_n clears parse state, the pipeline valids and restores register
//   defaults (4096, 65535, '/', 0).
// Stall:
//   While a result waits on m_tready, non-final characters keep flowing;
//   a final character waits in the input register, then s_tready drops.
`default_nettype none

module pipe_spec_parser
#(
    parameter int NAME_CAPACITY = 128
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] char_code, [8] char_present, [15:9] zero
    input  wire logic [psp_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] parse_ok, [32:1] pipe_size, [39:33] name_start, [46:40] name_length,
    // [48:47] tap_kind, [55:49] tap_start
    output logic      [psp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                m_tlast,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [psp_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [psp_pkg::DATA_W-1:0]      pwdata,
    output logic      [psp_pkg::DATA_W-1:0]      prdata,
    output logic                                pready
);
    import psp_pkg::*;

    cfg_t        cfg;
    result_t     result;
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_present_reg;
    logic        in_final_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;
    logic        advance;
    logic        s_take;

    psp_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psp_parser #(.NAME_CAPACITY(NAME_CAPACITY)) u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step_en      (advance),
        .step_char    (in_char_reg),
        .step_present (in_present_reg),
        .step_final   (in_final_reg),
        .result       (result)
    );

    assign advance  = in_valid_reg && (!in_final_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_char_reg    <= s_tdata[7:0];
            in_present_reg <= s_tdata[8];
            in_final_reg   <= s_tlast;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (advance && in_final_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_final_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = 1'b1;
    assign m_tdata  = {out_data_reg.tap_start, out_data_reg.tap_kind,
                       out_data_reg.name_length, out_data_reg.name_start,
                       out_data_reg.pipe_size, out_data_reg.parse_ok};

endmodule

`default_nettype wire

// ===== rtl/core/psp_checker.sv =====
// Port-level assertion checker for the pipe spec parser, bound to the top level.
`default_nettype none

module psp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tlast)
        else $error("result without end marker");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |->
            m_tdata[32:1] == 32'd0 && m_tdata[48:47] == 2'd0 && m_tdata[55:49] == 7'd0)
        else $error("failed parse carries size or tap");

    a_tap_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[48:47] != 2'd2 |-> m_tdata[55:49] == 7'd0 && m_tdata[48:47] != 2'd3)
        else $error("tap start without given tap");

    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] && m_tdata[48:47] != 2'd0 |-> m_tdata[32:1] != 32'd0
            || m_tdata[48:47] == 2'd2)
        else $error("valid parse with tap reports zero size");

endmodule

bind pipe_spec_parser psp_checker u_psp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== tb/pipe_spec_parser_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pipe_spec_parser: directed and random name strings over the stream ports.
module pipe_spec_parser_tb;
    import psp_pkg::*;

    localparam int NAME_CAP    = 128;
    localparam int ITEM_TARGET = 1950;
    localparam int PHASES      = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_CAP   = 100;

    typedef struct {
        logic [7:0] code;
        logic       present;
        logic       last;
    } char_item_t;

    class spec_scoreboard;
        logic [31:0] default_size;
        logic [31:0] size_limit;
        logic [7:0]  separator;
        logic        console_only;

        phase_t      phase;
        logic        colon_seen;
        logic        text_done;
        logic [7:0]  stored;
        logic [6:0]  name_origin;
        logic [6:0]  name_span;
        logic [31:0] size_value;
        radix_t      radix;
        logic [6:0]  tap_origin;
        logic [2:0]  con_matched;
        logic        bad;

        result_t     expected_q[$];
        int unsigned fails;

        function new();
            default_size = DEFAULT_SIZE_RST;
            size_limit   = SIZE_LIMIT_RST;
            separator    = SEPARATOR_RST;
            console_only = 1'b0;
            fails        = 0;
            clear_string();
        endfunction

        function void restart(logic [7:0] origin);
            phase       = PH_NAME;
            name_origin = origin[6:0];
            name_span   = '0;
            size_value  = '0;
            radix       = RADIX_DEC;
            tap_origin  = '0;
            con_matched = '0;
            bad         = 1'b0;
        endfunction

        function void clear_string();
            restart(8'd0);
            colon_seen = 1'b0;
            text_done  = 1'b0;
            stored     = '0;
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            return (c >= "a" && c <= "z") ? (c & 8'hDF) : c;
        endfunction

        function int hex_value(logic [7:0] c);
            logic [7:0] f;
            f = fold(c);
            if (f >= "0" && f <= "9")
            begin
                return int'(f - CHAR_ZERO);
            end
            if (f >= "A" && f <= "F")
            begin
                return int'(f - "A") + 10;
            end
            return 16;
        endfunction

        function void con_track(logic [7:0] c);
            if (con_matched < CON_DONE)
            begin
                if (fold(c) == CON_TEXT[con_matched[1:0]])
                begin
                    con_matched = con_matched + 3'd1;
                end
                else
                begin
                    con_matched = CON_FAIL;
                end
            end
        endfunction

        function void size_digit(logic [7:0] c);
            int          radix_n;
            int          v;
            logic [63:0] nxt;
            radix_n = (radix == RADIX_HEX) ? 16 : ((radix == RADIX_OCT) ? 8 : 10);
            v = hex_value(c);
            if (v < radix_n)
            begin
                nxt = 64'(size_value) * 64'(radix_n) + 64'(v);
                if (nxt > 64'(size_limit))
                begin
                    bad = 1'b1;
                end
                else
                begin
                    size_value = nxt[31:0];
                end
            end
            else if (c == separator)
            begin
                if (size_value == 0)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    phase = PH_TAP_START;
                end
            end
            else
            begin
                bad = 1'b1;
            end
        endfunction

        function void take_char(logic [7:0] c, logic [6:0] pos);
            if (!colon_seen && c == CHAR_COLON)
            begin
                colon_seen = 1'b1;
                restart({1'b0, pos} + 8'd1);
                return;
            end
            if (bad)
            begin
                return;
            end
            case (phase)
                PH_NAME:
                begin
                    if (c == separator)
                    begin
                        phase = PH_SIZE_START;
                    end
                    else
                    begin
                        name_span = name_span + 7'd1;
                    end
                end
                PH_SIZE_START:
                begin
                    if (c >= "0" && c <= "9")
                    begin
                        if (c == CHAR_ZERO)
                        begin
                            phase = PH_ZERO;
                        end
                        else
                        begin
                            radix      = RADIX_DEC;
                            size_value = 32'(c - CHAR_ZERO);
                            if (size_value > size_limit)
                            begin
                                bad = 1'b1;
                            end
                            phase = PH_DIGITS;
                        end
                    end
                    else
                    begin
                        tap_origin = pos;
                        phase      = PH_TAP;
                        con_track(c);
                    end
                end
                PH_ZERO:
                begin
                    phase = PH_DIGITS;
                    if (fold(c) == CHAR_X)
                    begin
                        radix = RADIX_HEX;
                    end
                    else
                    begin
                        radix = RADIX_OCT;
                        size_digit(c);
                    end
                end
                PH_DIGITS:
                begin
                    size_digit(c);
                end
                PH_TAP_START:
                begin
                    tap_origin = pos;
                    phase      = PH_TAP;
                    con_track(c);
                end
                default:
                begin
                    con_track(c);
                end
            endcase
        endfunction

        // one accepted input transaction; a final one queues the expected result
        function void note_input(logic [7:0] c, logic present, logic last);
            result_t r;
            if (present && !text_done)
            begin
                if (c == CHAR_NUL)
                begin
                    text_done = 1'b1;
                end
                else if (int'(stored) < NAME_CAP - 1)
                begin
                    stored = stored + 8'd1;
                    take_char(c, 7'(stored - 8'd1));
                end
            end
            if (!last)
            begin
                return;
            end
            r.parse_ok    = !bad;
            r.pipe_size   = default_size;
            r.name_start  = name_origin;
            r.name_length = name_span;
            r.tap_kind    = TAP_NONE;
            r.tap_start   = '0;
            case (phase)
                PH_SIZE_START:
                begin
                    r.tap_kind = TAP_DEFAULT;
                end
                PH_ZERO, PH_DIGITS:
                begin
                    if (size_value == 0)
                    begin
                        r.parse_ok = 1'b0;
                    end
                    r.pipe_size = size_value;
                end
                PH_TAP_START:
                begin
                    r.pipe_size = size_value;
                    r.tap_kind  = TAP_DEFAULT;
                end
                PH_TAP:
                begin
                    if (size_value != 0)
                    begin
                        r.pipe_size = size_value;
                    end
                    r.tap_kind  = TAP_GIVEN;
                    r.tap_start = tap_origin;
                    if (console_only && con_matched != CON_DONE)
                    begin
                        r.parse_ok = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (!r.parse_ok)
            begin
                r.pipe_size = '0;
                r.tap_kind  = TAP_NONE;
                r.tap_start = '0;
            end
            expected_q.push_back(r);
            clear_string();
        endfunction

        task report_mismatch(string what);
            fails++;
            if (fails <= PRINT_CAP)
            begin
                $display("%0t mismatch: %s", $realtime, what);
            end
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
            end
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", data));
                return;
            end
            want = expected_q.pop_front();
            check_field("parse_ok", 32'(data[0]), 32'(want.parse_ok));
            check_field("pipe_size", data[32:1], want.pipe_size);
            check_field("name_start", 32'(data[39:33]), 32'(want.name_start));
            check_field("name_length", 32'(data[46:40]), 32'(want.name_length));
            check_field("tap_kind", 32'(data[48:47]), 32'(want.tap_kind));
            check_field("tap_start", 32'(data[55:49]), 32'(want.tap_start));
            check_field("end_of_result", 32'(last), 32'd1);
        endtask
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [DATA_W-1:0]      pwdata   = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    spec_scoreboard sb;
    char_item_t     pending_items[$];
    int             items_sent    = 0;
    int             hold_requests = 0;
    logic           calm          = 1'b0;
    logic           sprinkle      = 1'b0;

    pipe_spec_parser #(
        .NAME_CAPACITY(NAME_CAP)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata, m_tlast);
            end
            if (s_tvalid && s_tready)
            begin
                sb.note_input(s_tdata[7:0], s_tdata[8], s_tlast);
            end
        end
    end

    // result side: random back-pressure plus long hold-offs on request
    initial
    begin : receiver
        int   hold_left;
        int   hold_seen;
        logic calm_now;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            calm_now = calm;
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm_now)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= 7);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_DEFAULT_SIZE: sb.default_size = value;
            REG_SIZE_LIMIT:   sb.size_limit   = value;
            REG_SEPARATOR:    sb.separator    = value[7:0];
            default:          sb.console_only = value[0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] dflt, input logic [31:0] limit,
                              input logic [7:0] sep, input logic con_only);
        write_reg(REG_DEFAULT_SIZE, dflt);
        write_reg(REG_SIZE_LIMIT, limit);
        write_reg(REG_SEPARATOR, {24'd0, sep});
        write_reg(REG_CONSOLE_ONLY, {31'd0, con_only});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (sb.expected_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_items();
        char_item_t it;
        while (pending_items.size() != 0)
        begin
            it = pending_items.pop_front();
            while (!calm && $urandom_range(99) < 7)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, it.present, it.code};
            s_tlast  <= it.last;
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            items_sent++;
        end
    endtask

    function automatic void add_char(logic [7:0] c);
        if (sprinkle && $urandom_range(99) < 4)
        begin
            pending_items.push_back('{8'($urandom_range(255)), 1'b0, 1'b0});
        end
        pending_items.push_back('{c, 1'b1, 1'b0});
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_char(s[i]);
        end
    endfunction

    function automatic void close_string(logic absent_last);
        if (absent_last || pending_items.size() == 0)
        begin
            pending_items.push_back('{8'($urandom_range(255)), 1'b0, 1'b1});
        end
        else
        begin
            pending_items[pending_items.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1))
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic string random_word(int len);
        string s;
        s = "";
        for (int i = 0; i < len; i++)
        begin
            s = {s, string'(flip_case(8'("a" + $urandom_range(25))))};
        end
        return s;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(7))
            0:       return sb.separator;
            1:       return CHAR_COLON;
            2:       return CHAR_ZERO;
            3:       return flip_case(CHAR_X);
            4:       return 8'("0" + $urandom_range(9));
            5:       return flip_case(8'("A" + $urandom_range(5)));
            6:       return 8'($urandom_range(255, 1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic string size_text();
        logic [31:0] v;
        string       s;
        case ($urandom_range(9))
            6:       v = sb.size_limit;
            7:       v = sb.size_limit + 32'd1;
            8:       v = $urandom;
            9:       v = '0;
            default: v = $urandom_range(sb.size_limit, 1);
        endcase
        case ($urandom_range(2))
            0:       s = $sformatf("%0d", v);
            1:       s = $sformatf("0%0o", v);
            default:
            begin
                s = $sformatf("%0h", v);
                if ($urandom_range(1))
                begin
                    s = s.toupper();
                end
                s = {$urandom_range(1) ? "0x" : "0X", s};
            end
        endcase
        return s;
    endfunction

    function automatic string tap_text();
        string s;
        s = "";
        case ($urandom_range(4))
            0, 1:
            begin
                s = {string'(flip_case("C")), string'(flip_case("O")), string'(flip_case("N")),
                     ":", random_word($urandom_range(6))};
            end
            2, 3:    s = random_word($urandom_range(8, 1));
            default: s = "";
        endcase
        return s;
    endfunction

    function automatic void build_wellformed();
        string sep;
        sep = string'(sb.separator);
        if ($urandom_range(2) == 0)
        begin
            add_text({random_word($urandom_range(4, 1)), ":"});
        end
        add_text(random_word($urandom_range(8)));
        case ($urandom_range(3))
            0:       ;
            1:       add_text({sep, size_text()});
            2:       add_text({sep, size_text(), sep, tap_text()});
            default: add_text({sep, tap_text()});
        endcase
    endfunction

    function automatic void build_random_string();
        int pick;
        int len;
        int colon_at;
        int idx;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            build_wellformed();
        end
        else if (pick < 72)
        begin
            build_wellformed();
            if (pending_items.size() != 0)
            begin
                idx = $urandom_range(pending_items.size() - 1);
                pending_items[idx].code    = noise_char();
                pending_items[idx].present = 1'b1;
            end
        end
        else if (pick < 88)
        begin
            len = $urandom_range(20, 1);
            for (int i = 0; i < len; i++)
            begin
                add_char(noise_char());
            end
        end
        else if (pick < 95)
        begin
            // may run past capacity; a colon taken near the end moves the name origin far out
            len      = $urandom_range(160, 100);
            colon_at = $urandom_range(1) ? $urandom_range(140, 110) : -1;
            for (int i = 0; i < len; i++)
            begin
                if (i == colon_at)
                begin
                    add_char(CHAR_COLON);
                end
                else if ($urandom_range(9) == 0)
                begin
                    add_char(noise_char());
                end
                else
                begin
                    add_char(flip_case(8'("a" + $urandom_range(25))));
                end
            end
        end
        if ($urandom_range(99) < 3)
        begin
            pending_items.push_back('{CHAR_NUL, 1'b1, 1'b1});
        end
        else
        begin
            close_string($urandom_range(1));
        end
    endfunction

    initial
    begin : main
        int directed_items;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed strings under reset settings
        close_string(1'b1);
        add_text("x:/0X1f/");
        close_string(1'b0);
        add_text("/00");
        close_string(1'b1);
        add_text("q/9z:a");
        close_string(1'b0);
        add_text("/7");
        add_char(CHAR_NUL);
        add_text("z");
        close_string(1'b0);
        send_items();
        directed_items = items_sent;
        sprinkle = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:       set_config(32'd1, 32'hFFFF_FFFF, "/", 1'b1);
                1:       set_config(32'hFFFF_FFFF, 32'd1, 8'hFF, 1'b0);
                2:       set_config($urandom_range(32'hFFFF_FFFF, 1), 32'd255, "5", 1'b1);
                3:       set_config($urandom_range(32'hFFFF_FFFF, 1), 32'd65535, CHAR_COLON,
                                    1'($urandom_range(1)));
                4:       set_config(32'd100, 32'd0, 8'h01, 1'b0);
                default: set_config(DEFAULT_SIZE_RST, 32'd1000, CHAR_ZERO, 1'b1);
            endcase
            calm = (p == 1);
            if (p == 3)
            begin
                hold_requests++;
            end
            while (items_sent < directed_items + ITEM_TARGET * (p + 1) / PHASES)
            begin
                build_random_string();
                send_items();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.fails == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
